@@ hw/rtl/arrowhead_point_geometry_unit_macros.svh @@
// Assertion macros for the arrowhead point geometry unit.
`ifndef ARROWHEAD_POINT_GEOMETRY_UNIT_MACROS_SVH
`define ARROWHEAD_POINT_GEOMETRY_UNIT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication check.
`define APGU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("apgu check failed");
// Next-cycle implication check.
`define APGU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("apgu check failed");
`else
`define APGU_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define APGU_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ hw/rtl/apgu_pkg.sv @@
// Shared constants, types and step functions for the arrowhead point geometry unit.
package apgu_pkg;

    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 16;
    localparam int LEN_FRAC   = 6;
    localparam int TRIG_BITS  = 14;
    localparam int SIZE_W     = 10;
    localparam int TRIG_W     = 15;

    // Front widths
    localparam int DIFF_W = COORD_BITS + 1;
    localparam int MAG_W  = COORD_BITS;
    localparam int LEN2_W = 2 * MAG_W + 1;

    // Square root pipeline
    localparam int SQ_RAW_W  = LEN2_W + 2 * LEN_FRAC;
    localparam int SQ_IN_W   = SQ_RAW_W + (SQ_RAW_W % 2);
    localparam int ROOT_W    = SQ_IN_W / 2;
    localparam int SQ_REM_W  = ROOT_W + 3;
    localparam int SQ_STAGES = ROOT_W + 1;

    // Divider pipeline
    localparam int Q_W       = FRAC_BITS + 1;
    localparam int NUM_W     = MAG_W + FRAC_BITS + LEN_FRAC + 1;
    localparam int DIV_REM_W = ROOT_W + 1;
    localparam int DV_STAGES = Q_W + 1;
    localparam int HALF_W    = ROOT_W - LEN_FRAC - 1;
    localparam int CMP_W     = (HALF_W > SIZE_W) ? HALF_W : SIZE_W;

    // Rotation and scaling
    localparam int UNIT_W = Q_W + 1;
    localparam int PROD_W = UNIT_W + TRIG_W + 1;
    localparam int ROT_W  = PROD_W + 1;
    localparam int SCL_W  = ROT_W + SIZE_W + 1;
    localparam int WSHIFT = FRAC_BITS + TRIG_BITS;
    localparam int V_W    = COORD_BITS + WSHIFT + 2;

    // Queue
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    // Register map
    localparam int PADDR_W = 4;
    localparam logic [1:0] REG_SIZE = 2'd0;
    localparam logic [1:0] REG_COS  = 2'd1;
    localparam logic [1:0] REG_SIN  = 2'd2;
    localparam logic [SIZE_W-1:0] RST_SIZE = SIZE_W'(20);
    localparam logic [TRIG_W-1:0] RST_COS  = TRIG_W'(14189);
    localparam logic [TRIG_W-1:0] RST_SIN  = TRIG_W'(8192);

    typedef struct packed {
        logic [SIZE_W-1:0] size;
        logic [TRIG_W-1:0] cos;
        logic [TRIG_W-1:0] sin;
    } t_cfg;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] ex;
        logic signed [COORD_BITS-1:0] ey;
        logic signed [DIFF_W-1:0]     dx;
        logic signed [DIFF_W-1:0]     dy;
        logic                         zero;
    } t_item_info;

    typedef struct packed {
        t_item_info        info;
        logic [LEN2_W-1:0] len2;
    } t_job;

    typedef struct packed {
        logic              push;
        logic              pop;
        logic              full;
        logic              empty;
        logic [QCNT_W-1:0] count;
    } t_q_stat;

    typedef struct packed {
        logic [SQ_REM_W-1:0] rem;
        logic [ROOT_W-1:0]   root;
        logic [SQ_IN_W-1:0]  x;
    } t_sq_st;

    typedef struct packed {
        logic [DIV_REM_W-1:0] rem;
        logic [Q_W-1:0]       q;
        logic [Q_W-1:0]       n;
    } t_dv_lane;

    function automatic logic [MAG_W-1:0] abs_mag(input logic signed [DIFF_W-1:0] d);
        logic [DIFF_W-1:0] m;
        m = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
        return m[MAG_W-1:0];
    endfunction

    // One result bit of the digit-by-digit square root.
    function automatic t_sq_st sqrt_step(input t_sq_st s);
        t_sq_st o;
        logic [SQ_REM_W-1:0] cur;
        logic [SQ_REM_W-1:0] trial;
        cur   = {s.rem[SQ_REM_W-3:0], s.x[SQ_IN_W-1 -: 2]};
        trial = {1'b0, s.root, 2'b01};
        if (cur >= trial) begin
            o.rem  = cur - trial;
            o.root = {s.root[ROOT_W-2:0], 1'b1};
        end else begin
            o.rem  = cur;
            o.root = {s.root[ROOT_W-2:0], 1'b0};
        end
        o.x = s.x << 2;
        return o;
    endfunction

    // One quotient bit of restoring division.
    function automatic t_dv_lane div_step(input t_dv_lane s, input logic [ROOT_W-1:0] d);
        t_dv_lane o;
        logic [DIV_REM_W-1:0] cur;
        cur = {s.rem[DIV_REM_W-2:0], s.n[Q_W-1]};
        if (cur >= {1'b0, d}) begin
            o.rem = cur - {1'b0, d};
            o.q   = {s.q[Q_W-2:0], 1'b1};
        end else begin
            o.rem = cur;
            o.q   = {s.q[Q_W-2:0], 1'b0};
        end
        o.n = s.n << 1;
        return o;
    endfunction

    // Divider setup: |d| scaled plus half the divisor, split for the first step.
    function automatic t_dv_lane div_init(input logic signed [DIFF_W-1:0] d,
                                          input logic [ROOT_W-1:0] len);
        t_dv_lane o;
        logic [NUM_W-1:0] num;
        num   = NUM_W'({abs_mag(d), {(FRAC_BITS + LEN_FRAC){1'b0}}}) + NUM_W'(len >> 1);
        o.rem = DIV_REM_W'(num[NUM_W-1:Q_W]);
        o.q   = '0;
        o.n   = num[Q_W-1:0];
        return o;
    endfunction

    // Round to nearest (ties away from zero), then saturate to the coordinate range.
    function automatic logic signed [COORD_BITS-1:0] round_sat(input logic signed [V_W-1:0] v);
        logic [V_W-1:0] mag;
        logic [V_W-1:0] rq;
        logic signed [V_W-1:0] w;
        mag = v[V_W-1] ? V_W'(-v) : V_W'(v);
        rq  = (mag + (V_W'(1) << (WSHIFT - 1))) >> WSHIFT;
        w   = v[V_W-1] ? -$signed(rq) : $signed(rq);
        if (w > $signed(V_W'((1 << (COORD_BITS - 1)) - 1)))
            return COORD_BITS'((1 << (COORD_BITS - 1)) - 1);
        else if (w < -$signed(V_W'(1 << (COORD_BITS - 1))))
            return COORD_BITS'(1 << (COORD_BITS - 1));
        else
            return w[COORD_BITS-1:0];
    endfunction

endpackage

@@ hw/rtl/apgu_front.sv @@
// Front end: accepts line words, forms the difference vector, squared length and class.
module apgu_front import apgu_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic signed [COORD_BITS-1:0] i_start_x,
    input  logic signed [COORD_BITS-1:0] i_start_y,
    input  logic signed [COORD_BITS-1:0] i_end_x,
    input  logic signed [COORD_BITS-1:0] i_end_y,
    input  logic                         i_full,
    output logic                         o_push,
    output t_job                         o_job
);

    logic         en;
    logic         r_a_v;
    logic         r_b_v;
    t_item_info   r_a_info;
    t_item_info   r_b_info;
    t_item_info   n_a_info;
    logic [2*MAG_W-1:0] r_sqx;
    logic [2*MAG_W-1:0] r_sqy;

    // Whole front stalls while the queue is full
    assign en         = !i_full;
    assign o_in_ready = en;
    assign o_push     = en && r_b_v;

    // Difference vector and zero-length class
    always_comb begin
        n_a_info.ex   = i_end_x;
        n_a_info.ey   = i_end_y;
        n_a_info.dx   = DIFF_W'(i_end_x) - DIFF_W'(i_start_x);
        n_a_info.dy   = DIFF_W'(i_end_y) - DIFF_W'(i_start_y);
        n_a_info.zero = (i_end_x == i_start_x) && (i_end_y == i_start_y);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
        end else if (en) begin
            r_a_v <= i_in_valid;
            r_b_v <= r_a_v;
        end
    end

    // Payload: squares registered before the sum
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_info <= n_a_info;
            r_b_info <= r_a_info;
            r_sqx    <= abs_mag(r_a_info.dx) * abs_mag(r_a_info.dx);
            r_sqy    <= abs_mag(r_a_info.dy) * abs_mag(r_a_info.dy);
        end
    end

    assign o_job.info = r_b_info;
    assign o_job.len2 = LEN2_W'(r_sqx) + LEN2_W'(r_sqy);

endmodule

@@ hw/rtl/apgu_queue.sv @@
// Short queue of classified jobs between front and back.
module apgu_queue import apgu_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_job    i_job,
    input  logic    i_pop,
    output t_job    o_job,
    output t_q_stat o_stat
);

    t_job              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QCNT_W-1:0] r_cnt;

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            if (i_push && !i_pop)      r_cnt <= r_cnt + 1'b1;
            else if (!i_push && i_pop) r_cnt <= r_cnt - 1'b1;
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_job;
    end

    assign o_job        = r_mem[r_rp];
    assign o_stat.push  = i_push;
    assign o_stat.pop   = i_pop;
    assign o_stat.full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_stat.count = r_cnt;

endmodule

@@ hw/rtl/apgu_back.sv @@
// Back end: square root, unit vector divide, rotation, scaling, rounding and output word.
module apgu_back import apgu_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_job_valid,
    input  t_job                         i_job,
    output logic                         o_take,
    input  t_cfg                         i_cfg,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic signed [COORD_BITS-1:0] o_wing_one_x,
    output logic signed [COORD_BITS-1:0] o_wing_one_y,
    output logic signed [COORD_BITS-1:0] o_wing_two_x,
    output logic signed [COORD_BITS-1:0] o_wing_two_y
);

    logic en;

    // Square root stages
    logic       r_sq_v [SQ_STAGES];
    t_item_info r_sq_i [SQ_STAGES];
    t_sq_st     r_sq   [SQ_STAGES];
    t_sq_st     n_sq   [SQ_STAGES];

    // Divider stages
    logic              r_dv_v  [DV_STAGES];
    t_item_info        r_dv_i  [DV_STAGES];
    t_dv_lane          r_dx    [DV_STAGES];
    t_dv_lane          r_dy    [DV_STAGES];
    logic [ROOT_W-1:0] r_dd    [DV_STAGES];
    logic [SIZE_W-1:0] r_dsz   [DV_STAGES];
    t_dv_lane          n_dx    [DV_STAGES];
    t_dv_lane          n_dy    [DV_STAGES];

    logic [ROOT_W-1:0] root_fin;
    logic [CMP_W-1:0]  half_c;
    logic [CMP_W-1:0]  size_c;
    logic [CMP_W-1:0]  size_sel;

    // Tail stages
    logic r_m0_v, r_m1_v, r_m2_v, r_m3_v, r_out_v;
    t_item_info r_m0_i, r_m1_i, r_m2_i, r_m3_i;
    logic [SIZE_W-1:0] r_m0_sz, r_m1_sz;
    logic signed [UNIT_W-1:0] ux, uy;
    logic signed [PROD_W-1:0] r_uxc, r_uys, r_uyc, r_uxs;
    logic signed [ROT_W-1:0]  r_r1x, r_r1y, r_r2x, r_r2y;
    logic signed [SCL_W-1:0]  r_s1x, r_s1y, r_s2x, r_s2y;
    logic signed [V_W-1:0]    r_v1x, r_v1y, r_v2x, r_v2y;
    logic signed [V_W-1:0]    ex_w, ey_w;

    // Whole back pipeline advances when the output word can move
    assign en          = !r_out_v || i_out_ready;
    assign o_take      = en;
    assign o_out_valid = r_out_v;

    // Next values of the square root chain
    always_comb begin
        n_sq[0].rem  = '0;
        n_sq[0].root = '0;
        n_sq[0].x    = SQ_IN_W'({i_job.len2, {(2 * LEN_FRAC){1'b0}}});
        for (int k = 1; k < SQ_STAGES; k++) begin
            n_sq[k] = sqrt_step(r_sq[k-1]);
        end
    end

    // Head size clamp and divider setup from the final root
    assign root_fin = r_sq[SQ_STAGES-1].root;
    assign half_c   = CMP_W'(root_fin >> (LEN_FRAC + 1));
    assign size_c   = CMP_W'(i_cfg.size);
    assign size_sel = (half_c < size_c) ? half_c : size_c;

    always_comb begin
        n_dx[0] = div_init(r_sq_i[SQ_STAGES-1].dx, root_fin);
        n_dy[0] = div_init(r_sq_i[SQ_STAGES-1].dy, root_fin);
        for (int k = 1; k < DV_STAGES; k++) begin
            n_dx[k] = div_step(r_dx[k-1], r_dd[k-1]);
            n_dy[k] = div_step(r_dy[k-1], r_dd[k-1]);
        end
    end

    // Signed unit vector
    assign ux = r_dv_i[DV_STAGES-1].dx[DIFF_W-1] ? -$signed({1'b0, r_dx[DV_STAGES-1].q})
                                                 :  $signed({1'b0, r_dx[DV_STAGES-1].q});
    assign uy = r_dv_i[DV_STAGES-1].dy[DIFF_W-1] ? -$signed({1'b0, r_dy[DV_STAGES-1].q})
                                                 :  $signed({1'b0, r_dy[DV_STAGES-1].q});

    assign ex_w = V_W'(r_m2_i.ex) <<< WSHIFT;
    assign ey_w = V_W'(r_m2_i.ey) <<< WSHIFT;

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SQ_STAGES; k++) r_sq_v[k] <= 1'b0;
            for (int k = 0; k < DV_STAGES; k++) r_dv_v[k] <= 1'b0;
            r_m0_v  <= 1'b0;
            r_m1_v  <= 1'b0;
            r_m2_v  <= 1'b0;
            r_m3_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else if (en) begin
            r_sq_v[0] <= i_job_valid;
            for (int k = 1; k < SQ_STAGES; k++) r_sq_v[k] <= r_sq_v[k-1];
            r_dv_v[0] <= r_sq_v[SQ_STAGES-1];
            for (int k = 1; k < DV_STAGES; k++) r_dv_v[k] <= r_dv_v[k-1];
            r_m0_v  <= r_dv_v[DV_STAGES-1];
            r_m1_v  <= r_m0_v;
            r_m2_v  <= r_m1_v;
            r_m3_v  <= r_m2_v;
            r_out_v <= r_m3_v;
        end
    end

    // Payload pipeline
    always_ff @(posedge i_clk) begin
        if (en) begin
            // square root
            r_sq_i[0] <= i_job.info;
            for (int k = 0; k < SQ_STAGES; k++) r_sq[k] <= n_sq[k];
            for (int k = 1; k < SQ_STAGES; k++) r_sq_i[k] <= r_sq_i[k-1];
            // divide
            r_dv_i[0] <= r_sq_i[SQ_STAGES-1];
            r_dd[0]   <= root_fin;
            r_dsz[0]  <= size_sel[SIZE_W-1:0];
            for (int k = 0; k < DV_STAGES; k++) begin
                r_dx[k] <= n_dx[k];
                r_dy[k] <= n_dy[k];
            end
            for (int k = 1; k < DV_STAGES; k++) begin
                r_dv_i[k] <= r_dv_i[k-1];
                r_dd[k]   <= r_dd[k-1];
                r_dsz[k]  <= r_dsz[k-1];
            end
            // rotation products
            r_m0_i  <= r_dv_i[DV_STAGES-1];
            r_m0_sz <= r_dsz[DV_STAGES-1];
            r_uxc   <= ux * $signed({1'b0, i_cfg.cos});
            r_uys   <= uy * $signed({1'b0, i_cfg.sin});
            r_uyc   <= uy * $signed({1'b0, i_cfg.cos});
            r_uxs   <= ux * $signed({1'b0, i_cfg.sin});
            // rotated vectors
            r_m1_i  <= r_m0_i;
            r_m1_sz <= r_m0_sz;
            r_r1x   <= ROT_W'(r_uxc) + ROT_W'(r_uys);
            r_r1y   <= ROT_W'(r_uyc) - ROT_W'(r_uxs);
            r_r2x   <= ROT_W'(r_uxc) - ROT_W'(r_uys);
            r_r2y   <= ROT_W'(r_uyc) + ROT_W'(r_uxs);
            // scale by head size
            r_m2_i  <= r_m1_i;
            r_s1x   <= $signed({1'b0, r_m1_sz}) * r_r1x;
            r_s1y   <= $signed({1'b0, r_m1_sz}) * r_r1y;
            r_s2x   <= $signed({1'b0, r_m1_sz}) * r_r2x;
            r_s2y   <= $signed({1'b0, r_m1_sz}) * r_r2y;
            // offset from the end point
            r_m3_i  <= r_m2_i;
            r_v1x   <= ex_w - V_W'(r_s1x);
            r_v1y   <= ey_w - V_W'(r_s1y);
            r_v2x   <= ex_w - V_W'(r_s2x);
            r_v2y   <= ey_w - V_W'(r_s2y);
            // round, saturate, zero-length bypass
            if (r_m3_i.zero) begin
                o_wing_one_x <= r_m3_i.ex;
                o_wing_one_y <= r_m3_i.ey;
                o_wing_two_x <= r_m3_i.ex;
                o_wing_two_y <= r_m3_i.ey;
            end else begin
                o_wing_one_x <= round_sat(r_v1x);
                o_wing_one_y <= round_sat(r_v1y);
                o_wing_two_x <= round_sat(r_v2x);
                o_wing_two_y <= round_sat(r_v2y);
            end
        end
    end

endmodule

@@ hw/rtl/arrowhead_point_geometry_unit.sv @@
// Arrowhead point geometry unit: top level with register port, front, queue and back.
// Throughput: one word per cycle when the output is not stalled; the square root (24
// stages) and divider (18 stages) are fully pipelined, a load stage followed by one
// result bit per stage.
// Reset: synchronous, active low; clears all valid bits, the queue and restores the
// registers to head_size 20, head_cos 14189, head_sin 8192.
module arrowhead_point_geometry_unit import apgu_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic signed [COORD_BITS-1:0] i_start_x,
    input  logic signed [COORD_BITS-1:0] i_start_y,
    input  logic signed [COORD_BITS-1:0] i_end_x,
    input  logic signed [COORD_BITS-1:0] i_end_y,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic signed [COORD_BITS-1:0] o_wing_one_x,
    output logic signed [COORD_BITS-1:0] o_wing_one_y,
    output logic signed [COORD_BITS-1:0] o_wing_two_x,
    output logic signed [COORD_BITS-1:0] o_wing_two_y,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [PADDR_W-1:0]           paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

`include "arrowhead_point_geometry_unit_macros.svh"

    t_cfg    r_cfg;
    logic    cfg_wr;
    logic    push;
    logic    pop;
    logic    take;
    t_job    front_job;
    t_job    queue_job;
    t_q_stat q_stat;

    // Register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.size <= RST_SIZE;
            r_cfg.cos  <= RST_COS;
            r_cfg.sin  <= RST_SIN;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_SIZE: r_cfg.size <= pwdata[SIZE_W-1:0];
                REG_COS:  r_cfg.cos  <= pwdata[TRIG_W-1:0];
                REG_SIN:  r_cfg.sin  <= pwdata[TRIG_W-1:0];
                default:  ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_SIZE: prdata = 32'(r_cfg.size);
            REG_COS:  prdata = 32'(r_cfg.cos);
            REG_SIN:  prdata = 32'(r_cfg.sin);
            default:  prdata = '0;
        endcase
    end

    apgu_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_start_x  (i_start_x),
        .i_start_y  (i_start_y),
        .i_end_x    (i_end_x),
        .i_end_y    (i_end_y),
        .i_full     (q_stat.full),
        .o_push     (push),
        .o_job      (front_job)
    );

    assign pop = take && !q_stat.empty;

    apgu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_job   (queue_job),
        .o_stat  (q_stat)
    );

    apgu_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job_valid  (!q_stat.empty),
        .i_job        (queue_job),
        .o_take       (take),
        .i_cfg        (r_cfg),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_wing_one_x (o_wing_one_x),
        .o_wing_one_y (o_wing_one_y),
        .o_wing_two_x (o_wing_two_x),
        .o_wing_two_y (o_wing_two_y)
    );

    // Checks
    `APGU_ASSERT_NOW(a_q_count, i_clk, i_rst_n, 1'b1, q_stat.count <= QCNT_W'(QDEPTH))
    `APGU_ASSERT_NOW(a_no_push_full, i_clk, i_rst_n, q_stat.push, !q_stat.full)
    `APGU_ASSERT_NOW(a_pop_nonempty, i_clk, i_rst_n, q_stat.pop, !q_stat.empty)
    `APGU_ASSERT_NEXT(a_push_counts, i_clk, i_rst_n, q_stat.push && !q_stat.pop, q_stat.count == $past(q_stat.count) + 1'b1)

endmodule
